[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TRC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Same, on the usual clk_i and rst_ni of the module.
`define TRC_ASSERT_DEF(lbl, prop) `TRC_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

[design/trc_pkg.sv]
package trc_pkg;

  // Timestamp slot; the rtt field spans exactly one slot.
  localparam int unsigned TsSlot = 65536;

  localparam logic [15:0] MinReplyBytes    = 16'd56;
  localparam logic [5:0]  MaxHops          = 6'd32;
  localparam logic [7:0]  TypeUnreach      = 8'd3;
  localparam logic [7:0]  TypeTimeExceeded = 8'd11;
  localparam logic [7:0]  CodeTtlInTransit = 8'd0;
  // Unreachable codes that mark a reply from the destination itself.
  localparam logic [7:0]  CodeDestFirst    = 8'd1;
  localparam logic [7:0]  CodeDestLast     = 8'd3;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgChecksumOffset = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTtlOffset      = 1'd1;

  typedef enum logic [2:0] {
    StReported    = 3'd0,
    StIgnored     = 3'd1,
    StPortMismatch = 3'd2,
    StOtherUnreach = 3'd3,
    StOtherType   = 3'd4,
    StAbnormal    = 3'd5
  } status_e;

  // Input word payload, last field in the lowest bits.
  typedef struct packed {
    logic [15:0] now_ms;
    logic [7:0]  quoted_ttl;
    logic [15:0] quoted_ip_len;
    logic [15:0] quoted_ip_id;
    logic [15:0] quoted_src_port;
    logic [31:0] quoted_dest_addr;
    logic [31:0] responder_addr;
    logic [7:0]  reply_code;
    logic [7:0]  reply_type;
    logic [15:0] packet_length;
  } in_data_t;

  typedef struct packed {
    logic     is_icmp;
    in_data_t data;
  } item_t;

  typedef struct packed {
    logic [CfgDataW-1:0] checksum_offset;
    logic [7:0]          ttl_offset;
  } cfg_t;

  // Per-word result, excluding the counters.
  typedef struct packed {
    status_e     status;
    logic [31:0] destination;
    logic [31:0] responder;
    logic [7:0]  distance;
    logic [15:0] rtt;
    logic        from_destination;
  } res_t;

  typedef struct packed {
    logic mismatch;
    logic abnormal;
    logic other;
  } cnt_inc_t;

  typedef struct packed {
    logic [31:0] other_count;
    logic [31:0] abnormal_count;
    logic [31:0] mismatch_count;
  } cnt_t;

  // Output word payload, last field in the lowest bits.
  typedef struct packed {
    logic [31:0] other_count;
    logic [31:0] abnormal_count;
    logic [31:0] mismatch_count;
    logic [15:0] rtt;
    logic [7:0]  distance;
    logic [31:0] responder;
    logic [31:0] destination;
  } out_data_t;

  typedef struct packed {
    logic    from_destination;
    status_e status;
  } out_user_t;

  localparam int unsigned InDataW   = $bits(in_data_t);
  localparam int unsigned OutDataW  = $bits(out_data_t);
  localparam int unsigned OutUserW  = $bits(out_user_t);

endpackage

[design/trc_decode.sv]
module trc_decode (
  input  trc_pkg::item_t    item_i,
  input  trc_pkg::cfg_t     cfg_i,
  output trc_pkg::res_t     res_o,
  output trc_pkg::cnt_inc_t inc_o
);
  import trc_pkg::*;

  logic [16:0]        fold_sum;
  logic [15:0]        fold;
  logic [15:0]        exp_port;
  logic [15:0]        sent;
  logic [16:0]        rtt_diff;
  logic [5:0]         init_base;
  logic [8:0]         init_ttl;
  logic signed [10:0] dist_unreach;
  logic signed [10:0] dist_te;
  logic signed [10:0] hop_dist;
  logic signed [10:0] lo_bound;
  logic signed [10:0] hi_bound;
  logic               is_dest_unreach;
  logic               is_time_exceeded;
  logic               out_of_range;
  in_data_t           d;

  assign d = item_i.data;

  always_comb begin
    // Expected source port: ones-complement fold of the address halves.
    fold_sum = {1'b0, d.quoted_dest_addr[31:16]} + {1'b0, d.quoted_dest_addr[15:0]};
    fold     = fold_sum[15:0] + 16'(fold_sum[16]);
    exp_port = ~fold + cfg_i.checksum_offset;

    sent     = {d.quoted_ip_len[6:1], d.quoted_ip_id[15:6]};
    rtt_diff = 17'(d.now_ms) + 17'(TsSlot) - 17'(sent);

    init_base = (d.quoted_ip_id[4:0] == 5'd0) ? MaxHops : {1'b0, d.quoted_ip_id[4:0]};
    init_ttl  = 9'(init_base) + 9'(cfg_i.ttl_offset);

    dist_unreach = $signed({2'b00, init_ttl}) - $signed({3'b000, d.quoted_ttl}) + 11'sd1;
    dist_te      = $signed({2'b00, init_ttl});
    lo_bound     = $signed({3'b000, cfg_i.ttl_offset});
    hi_bound     = $signed(11'(MaxHops) + {3'b000, cfg_i.ttl_offset});

    is_dest_unreach  = (d.reply_type == TypeUnreach) &&
                       (d.reply_code inside {[CodeDestFirst:CodeDestLast]});
    is_time_exceeded = (d.reply_type == TypeTimeExceeded) &&
                       (d.reply_code == CodeTtlInTransit);
    hop_dist         = is_dest_unreach ? dist_unreach : dist_te;
    out_of_range     = (hop_dist <= lo_bound) || (hop_dist > hi_bound);

    res_o = '0;
    inc_o = '0;
    if (!item_i.is_icmp || (d.packet_length < MinReplyBytes)) begin
      res_o.status = StIgnored;
    end else if (exp_port != d.quoted_src_port) begin
      res_o.status   = StPortMismatch;
      inc_o.mismatch = 1'b1;
    end else begin
      res_o.destination = d.quoted_dest_addr;
      res_o.responder   = d.responder_addr;
      res_o.rtt         = 16'(rtt_diff % 17'(TsSlot));
      if (is_dest_unreach || is_time_exceeded) begin
        if (out_of_range) begin
          res_o.status   = StAbnormal;
          inc_o.abnormal = 1'b1;
        end else begin
          res_o.status           = StReported;
          res_o.distance         = hop_dist[7:0];
          res_o.from_destination = is_dest_unreach;
        end
      end else if (d.reply_type == TypeUnreach) begin
        res_o.status = StOtherUnreach;
      end else begin
        res_o.status = StOtherType;
        inc_o.other  = 1'b1;
      end
    end
  end

endmodule

[design/trc_counters.sv]
module trc_counters (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  trc_pkg::cnt_inc_t inc_i,
  output trc_pkg::cnt_t     cnt_o
);
  import trc_pkg::*;

  logic [31:0] mismatch_q, mismatch_d;
  logic [31:0] abnormal_q, abnormal_d;
  logic [31:0] other_q, other_d;

  // Each counter sticks at all ones once it gets there.
  always_comb begin
    mismatch_d = mismatch_q;
    abnormal_d = abnormal_q;
    other_d    = other_q;
    if (en_i && inc_i.mismatch && (mismatch_q != '1)) mismatch_d = mismatch_q + 32'd1;
    if (en_i && inc_i.abnormal && (abnormal_q != '1)) abnormal_d = abnormal_q + 32'd1;
    if (en_i && inc_i.other && (other_q != '1))       other_d    = other_q + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_q <= '0;
      abnormal_q <= '0;
      other_q    <= '0;
    end else begin
      mismatch_q <= mismatch_d;
      abnormal_q <= abnormal_d;
      other_q    <= other_d;
    end
  end

  assign cnt_o.mismatch_count = mismatch_q;
  assign cnt_o.abnormal_count = abnormal_q;
  assign cnt_o.other_count    = other_q;

endmodule

[design/traceroute_reply_classifier.sv]
// Traceroute reply classifier.
// The slave stream carries one word per received reply: tuser holds the
// ICMP socket flag and tdata the reply length, outer ICMP type and code, the
// responder address and the quoted probe fields with the current time. The
// master stream returns one word per reply: tuser holds the status and the
// destination-unreachable flag, tdata the decoded report and the three
// saturating counters as they stand once that reply has been counted.
// The configuration channel writes checksum_offset (index 0) and ttl_offset
// (index 1); it is always ready, and writes are expected only while no word
// is in flight. Writes to any other index are dropped.
// An accepted word is latched in the input register, and its result is
// latched in the result register once that register is free, and then
// offered on the master stream. One word can be accepted every cycle while
// the receiver keeps taking results; the decode between the two registers
// is a single shallow pass of adders and compares.
// Reset clears both valid flags, the configuration registers and the
// counters. When the receiver stalls, the result word holds, the input
// register still takes a word while the result register is occupied, and
// only then does tready fall.
module traceroute_reply_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata, low bit up: packet_length, reply type, reply code, responder_addr,
  // quoted_dest_addr, quoted_src_port, quoted_ip_id, quoted_ip_len,
  // quoted_ttl, now_ms.
  input  logic [trc_pkg::InDataW-1:0]   s_axis_tdata_i,
  // tuser: is_icmp.
  input  logic                          s_axis_tuser_i,
  // Master stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata, low bit up: destination, responder, distance, rtt,
  // mismatch_count, abnormal_count, other_count.
  output logic [trc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // tuser, low bit up: status, from_destination.
  output logic [trc_pkg::OutUserW-1:0]  m_axis_tuser_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [trc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import trc_pkg::*;

  cfg_t     cfg_q;
  item_t    item_q;
  logic     in_valid_q;
  res_t     res_q;
  logic     out_valid_q;
  res_t     res;
  cnt_inc_t inc;
  cnt_t     cnt;
  logic     out_free;
  logic     advance;
  logic     s_accept;
  out_data_t out_data;
  out_user_t out_user;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgChecksumOffset: cfg_q.checksum_offset <= cfg_data_i;
        CfgTtlOffset:      cfg_q.ttl_offset      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The result register is free when empty or being drained this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (out_free)        out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q.is_icmp <= s_axis_tuser_i;
      item_q.data    <= in_data_t'(s_axis_tdata_i);
    end
    if (advance) res_q <= res;
  end

  trc_decode u_decode (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res),
    .inc_o  (inc)
  );

  // Counters move only when a word enters the result register, so they
  // always match the word on offer.
  trc_counters u_counters (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .inc_i  (inc),
    .cnt_o  (cnt)
  );

  always_comb begin
    out_data.destination    = res_q.destination;
    out_data.responder      = res_q.responder;
    out_data.distance       = res_q.distance;
    out_data.rtt            = res_q.rtt;
    out_data.mismatch_count = cnt.mismatch_count;
    out_data.abnormal_count = cnt.abnormal_count;
    out_data.other_count    = cnt.other_count;
    out_user.status           = res_q.status;
    out_user.from_destination = res_q.from_destination;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data;
  assign m_axis_tuser_o  = out_user;

endmodule

[design/trc_checker.sv]
`include "assert_macros.svh"

module trc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [trc_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [trc_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import trc_pkg::*;

  // A stalled result word stays offered.
  `TRC_ASSERT_DEF(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)

  // The mismatch counter never goes backwards.
  `TRC_ASSERT_DEF(a_mismatch_mono, m_axis_tdata_o[119:88] >= $past(m_axis_tdata_o[119:88]))

  // The destination flag only comes with a reported distance.
  `TRC_ASSERT_DEF(a_fromd_reported, m_axis_tvalid_o && m_axis_tuser_o[3] |-> m_axis_tuser_o[2:0] == StReported)

  // An ignored reply carries no report.
  `TRC_ASSERT_DEF(a_ignored_empty, m_axis_tvalid_o && m_axis_tuser_o[2:0] == StIgnored |-> m_axis_tdata_o[87:0] == '0)

endmodule

bind traceroute_reply_classifier trc_checker u_trc_checker (.*);
